### rtl/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

  localparam int NUM_VOICES_DEF = 12;
  localparam int NUM_CLIPS_DEF  = 8;

  // sample memory geometry and channel format
  localparam int MEMORY_FRAMES = 65536;
  localparam int MEM_AW        = $clog2(MEMORY_FRAMES);
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAME_W       = 2 * SAMPLE_BITS;

  // field widths
  localparam int FUNC_W     = 2;
  localparam int CLIP_ID_W  = 3;
  localparam int ADDR_W     = 16;
  localparam int POS_W      = 17;
  localparam int GAIN_W     = 9;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // stream payload layout
  localparam int S_FIELDS_W = CLIP_ID_W + ADDR_W + POS_W + 2 * SAMPLE_BITS;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = 2 * SAMPLE_BITS;

  localparam int OFS_CLIP_ID = 0;
  localparam int OFS_ADDR    = OFS_CLIP_ID + CLIP_ID_W;
  localparam int OFS_FRAMES  = OFS_ADDR + ADDR_W;
  localparam int OFS_LEFT    = OFS_FRAMES + POS_W;
  localparam int OFS_RIGHT   = OFS_LEFT + SAMPLE_BITS;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(128);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_PLAY  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_DESC  = 2'd3
  } func_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MUSIC_ENABLE     = 3'd0,
    REG_MUSIC_BASE       = 3'd1,
    REG_MUSIC_LENGTH     = 3'd2,
    REG_MUSIC_LOOP_START = 3'd3,
    REG_MUSIC_GAIN       = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

### rtl/svm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/sample_voice_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample playback voice mixer with looping background music.
// Input stream (s_*): tuser carries the function, tdata the operands. A sample
// write, a clip descriptor write or a play request gives no output. A tick
// walks all voices and the music track and emits one stereo frame on the
// output stream (m_*).
// The voice walk reads one voice entry a cycle from the voice state RAM and
// one frame a cycle from the single read port of the sample RAM; then come
// the music read, the gain multiply, the sum and the saturate steps. Other
// functions are taken every cycle while no tick is in progress.
// The output register lets the next item be taken while a frame waits; a tick
// that finds the previous frame still untaken holds in its last step until
// m_tready frees the register.
// Reset clears all voices, the clip lengths, the music position and the
// configuration registers (gain goes to 128). Sample memory content is
// undefined until written. The configuration port must be written only while idle; the block does not enforce it.
module sample_voice_mixer_unit
  import svm_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF,
  parameter int NUM_CLIPS  = NUM_CLIPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // clip_id, address, clip_frames, left_in, right_in, zero pad
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // func
  input  wire logic [FUNC_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // left_out, right_out
  output logic      [M_TDATA_W-1:0]  m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CLIP_W = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
  localparam int CNT_W  = $clog2(NUM_VOICES + 2);
  localparam int VOICE_W = CLIP_W + POS_W;
  localparam int ACC_W  = SAMPLE_BITS + $clog2(NUM_VOICES + 1) + 3;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_VOICE = 6'b000010,
    S_MUSIC = 6'b000100,
    S_MUL   = 6'b001000,
    S_SUM   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;

  // input fields
  func_t                   in_func;
  logic [CLIP_ID_W-1:0]    in_clip_id;
  logic [ADDR_W-1:0]       in_address;
  logic [POS_W-1:0]        in_frames;
  logic [SAMPLE_BITS-1:0]  in_left;
  logic [SAMPLE_BITS-1:0]  in_right;
  logic [CLIP_W-1:0]       in_clip;
  logic                    in_clip_ok;
  logic                    s_fire;

  assign in_func    = func_t'(s_tuser);
  assign in_clip_id = s_tdata[OFS_CLIP_ID +: CLIP_ID_W];
  assign in_address = s_tdata[OFS_ADDR +: ADDR_W];
  assign in_frames  = s_tdata[OFS_FRAMES +: POS_W];
  assign in_left    = s_tdata[OFS_LEFT +: SAMPLE_BITS];
  assign in_right   = s_tdata[OFS_RIGHT +: SAMPLE_BITS];
  assign in_clip    = CLIP_W'(in_clip_id);
  assign in_clip_ok = 32'(in_clip_id) < 32'(NUM_CLIPS);

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // configuration
  logic                  music_enable;
  logic [ADDR_W-1:0]     music_base;
  logic [POS_W-1:0]      music_length;
  logic [ADDR_W-1:0]     music_loop_start;
  logic [GAIN_W-1:0]     music_gain;
  logic [POS_W-1:0]      music_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      music_enable     <= 1'b0;
      music_base       <= '0;
      music_length     <= '0;
      music_loop_start <= '0;
      music_gain       <= GAIN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MUSIC_ENABLE:     music_enable     <= cfg_data[0];
        REG_MUSIC_BASE:       music_base       <= cfg_data[ADDR_W-1:0];
        REG_MUSIC_LENGTH:     music_length     <= cfg_data[POS_W-1:0];
        REG_MUSIC_LOOP_START: music_loop_start <= cfg_data[ADDR_W-1:0];
        REG_MUSIC_GAIN:       music_gain       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clip descriptors
  logic [ADDR_W-1:0] clip_start  [NUM_CLIPS];
  logic [POS_W-1:0]  clip_length [NUM_CLIPS];
  logic              desc_we;

  assign desc_we = s_fire && (in_func == FUNC_DESC) && in_clip_ok;

  always_ff @(posedge clk) begin
    if (desc_we) begin
      clip_start[in_clip] <= in_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLIPS; i++) begin
        clip_length[i] <= '0;
      end
    end else if (desc_we) begin
      clip_length[in_clip] <= in_frames;
    end
  end

  // voice busy bits and free voice search
  logic [NUM_VOICES-1:0] busy;
  logic [VIDX_W-1:0]     free_idx;
  logic                  play_fire;

  always_comb begin
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_idx = VIDX_W'(i);
      end
    end
  end

  assign play_fire = s_fire && (in_func == FUNC_PLAY) && in_clip_ok
                     && (clip_length[in_clip] != '0);

  // voice walk pipeline: a = voice entry read, b = sample read, c = accumulate
  logic [CNT_W-1:0]   cnt;
  logic               a_vld;
  logic [VIDX_W-1:0]  a_idx;
  logic               b_act;
  logic [VOICE_W-1:0] voice_rdata;
  logic [CLIP_W-1:0]  v_clip;
  logic [POS_W-1:0]   v_pos;
  logic [POS_W-1:0]   v_len;
  logic [ADDR_W-1:0]  v_start;
  logic               v_live;
  logic               v_ended;
  logic               v_play;
  logic               voice_we;
  logic [VIDX_W-1:0]  voice_waddr;
  logic [VOICE_W-1:0] voice_wdata;
  logic [POS_W:0]     v_addr_sum;

  assign v_clip     = voice_rdata[POS_W +: CLIP_W];
  assign v_pos      = voice_rdata[POS_W-1:0];
  assign v_len      = clip_length[v_clip];
  assign v_start    = clip_start[v_clip];
  assign v_live     = a_vld && busy[a_idx];
  assign v_ended    = v_pos >= v_len;
  assign v_play     = v_live && !v_ended;
  assign v_addr_sum = {1'b0, v_start} + {1'b0, v_pos};

  assign voice_we    = play_fire || v_play;
  assign voice_waddr = play_fire ? free_idx : a_idx;
  assign voice_wdata = play_fire ? {in_clip, POS_W'(0)} : {v_clip, v_pos + POS_W'(1)};

  svm_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (NUM_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (voice_we),
    .waddr (voice_waddr),
    .wdata (voice_wdata),
    .raddr (cnt[VIDX_W-1:0]),
    .rdata (voice_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (play_fire) begin
      busy[free_idx] <= 1'b1;
    end else if (v_live && v_ended) begin
      busy[a_idx] <= 1'b0;
    end
  end

  // music position with loop wrap
  logic              music_on;
  logic [POS_W-1:0]  music_pos_eff;
  logic [ADDR_W-1:0] music_addr;

  assign music_on = music_enable && (music_length != '0);

  always_comb begin
    music_pos_eff = music_position;
    if (music_position >= music_length) begin
      music_pos_eff = (POS_W'(music_loop_start) < music_length) ? POS_W'(music_loop_start)
                                                                : '0;
    end
  end

  assign music_addr = music_base + music_pos_eff[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      music_position <= '0;
    end else if (cfg_we && (reg_idx_t'(cfg_index) == REG_MUSIC_ENABLE)) begin
      music_position <= '0;
    end else if ((state == S_MUSIC) && music_on) begin
      music_position <= music_pos_eff + POS_W'(1);
    end
  end

  // sample memory
  logic               sample_we;
  logic [MEM_AW-1:0]  sample_raddr;
  logic [FRAME_W-1:0] sample_rdata;

  assign sample_we    = s_fire && (in_func == FUNC_WRITE);
  assign sample_raddr = (state == S_MUSIC) ? MEM_AW'(music_addr) : v_addr_sum[MEM_AW-1:0];

  svm_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MEMORY_FRAMES)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sample_we),
    .waddr (MEM_AW'(in_address)),
    .wdata ({in_right, in_left}),
    .raddr (sample_raddr),
    .rdata (sample_rdata)
  );

  // mixing datapath
  logic signed [ACC_W-1:0]       acc_l, acc_r;
  logic signed [PROD_W-1:0]      prod_l, prod_r;
  logic                          music_act;
  logic signed [SAMPLE_BITS-1:0] smp_l, smp_r;
  logic signed [GAIN_W:0]        gain_s;
  logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;
  logic                          out_load;

  assign smp_l  = $signed(sample_rdata[SAMPLE_BITS-1:0]);
  assign smp_r  = $signed(sample_rdata[FRAME_W-1:SAMPLE_BITS]);
  assign gain_s = $signed({1'b0, music_gain});

  always_comb begin
    if (acc_l > SAT_HI) begin
      sat_l = SAMPLE_BITS'(SAT_HI);
    end else if (acc_l < SAT_LO) begin
      sat_l = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_l = SAMPLE_BITS'(acc_l);
    end
    if (acc_r > SAT_HI) begin
      sat_r = SAMPLE_BITS'(SAT_HI);
    end else if (acc_r < SAT_LO) begin
      sat_r = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_r = SAMPLE_BITS'(acc_r);
    end
  end

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire && (in_func == FUNC_TICK)) begin
          state_next = S_VOICE;
        end
      end
      S_VOICE: begin
        if (cnt == CNT_W'(NUM_VOICES + 1)) begin
          state_next = S_MUSIC;
        end
      end
      S_MUSIC: state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      a_vld    <= 1'b0;
      b_act    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_VOICE) ? cnt + CNT_W'(1) : '0;
      a_vld <= (state == S_VOICE) && (cnt < CNT_W'(NUM_VOICES));
      b_act <= v_play;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= cnt[VIDX_W-1:0];
    if (state == S_MUSIC) begin
      music_act <= music_on;
    end
    if (state == S_MUL) begin
      prod_l <= PROD_W'(smp_l) * PROD_W'(gain_s);
      prod_r <= PROD_W'(smp_r) * PROD_W'(gain_s);
    end
    if (s_fire) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (b_act) begin
      acc_l <= acc_l + ACC_W'(smp_l);
      acc_r <= acc_r + ACC_W'(smp_r);
    end else if ((state == S_SUM) && music_act) begin
      // floor of product / 256
      acc_l <= acc_l + ACC_W'($signed(prod_l[PROD_W-1:8]));
      acc_r <= acc_r + ACC_W'($signed(prod_r[PROD_W-1:8]));
    end
    if (out_load) begin
      m_tdata <= {sat_r, sat_l};
    end
  end

  // a voice can only become busy through a play request
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && ($countones(busy) > $countones($past(busy)))) |-> $past(play_fire))
    else $error("voice became busy without a play transfer");

  // music position moves only in the music step or on an enable write
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (music_position != $past(music_position)))
      |-> ($past(state) == S_MUSIC || $past(cfg_we)))
    else $error("music position changed outside the music step");

  // a tick transfer starts the voice walk
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && (in_func == FUNC_TICK)) |=> (state == S_VOICE && cnt == '0))
    else $error("tick did not start the voice walk");

  // voice pipeline activity stays inside the walk
  assert property (@(posedge clk) disable iff (rst)
    (a_vld || b_act) |-> (state == S_VOICE))
    else $error("voice pipeline active outside the walk");

endmodule

`default_nettype wire

### test/sample_voice_mixer_unit_test.sv
`timescale 1ns / 1ps

module sample_voice_mixer_unit_test;
  import svm_pkg::*;

  localparam int NUM_VOICES    = NUM_VOICES_DEF;
  localparam int NUM_CLIPS     = NUM_CLIPS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 120;
  localparam logic [4:0] ALL_REGS = 5'b11111;

  typedef enum int { READY_FULL, READY_CHOPPY, READY_LONG_STALL } ready_mode_t;

  typedef struct {
    func_t                  func;
    logic [CLIP_ID_W-1:0]   clip_id;
    logic [ADDR_W-1:0]      address;
    logic [POS_W-1:0]       clip_frames;
    logic [SAMPLE_BITS-1:0] left_in;
    logic [SAMPLE_BITS-1:0] right_in;
  } mix_cmd_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } mix_frame_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = FUNC_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = REG_MUSIC_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mixer state as the block should hold it
  bit [FRAME_W-1:0]     mem_frame [MEMORY_FRAMES];
  bit                   mem_written [MEMORY_FRAMES];
  bit [ADDR_W-1:0]      clip_first [NUM_CLIPS];
  bit [POS_W-1:0]       clip_len [NUM_CLIPS];
  bit                   voice_on [NUM_VOICES];
  bit [CLIP_ID_W-1:0]   voice_clip_id [NUM_VOICES];
  bit [POS_W-1:0]       voice_pos [NUM_VOICES];
  bit [POS_W-1:0]       music_pos;
  bit                   music_on;
  bit [ADDR_W-1:0]      music_first;
  bit [POS_W-1:0]       music_len;
  bit [ADDR_W-1:0]      music_loop;
  bit [GAIN_W-1:0]      music_scale = GAIN_RESET;

  mix_frame_t        frames_due[$];
  logic [ADDR_W-1:0] fetch_addr[$];
  mix_frame_t        want;
  int                mismatch_count = 0;
  int                items_sent = 0;

  ready_mode_t ready_mode = READY_FULL;
  int          stall_cnt = 0;
  bit          gaps_on = 1'b0;
  bit          valid_held = 1'b0;
  int          burst_left = 1;

  sample_voice_mixer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    case (ready_mode)
      READY_FULL: m_tready <= 1'b1;
      READY_CHOPPY: m_tready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_cnt > 0) begin
          m_tready <= 1'b0;
          stall_cnt--;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_cnt = $urandom_range(1, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected output transfer: left_out %0d right_out %0d",
               $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
        mismatch_count++;
      end else begin
        want = frames_due.pop_front();
        if (m_tdata[15:0] !== want.left) begin
          $error("left_out: expected %0d, got %0d", $signed(want.left),
                 $signed(m_tdata[15:0]));
          mismatch_count++;
        end
        if (m_tdata[31:16] !== want.right) begin
          $error("right_out: expected %0d, got %0d", $signed(want.right),
                 $signed(m_tdata[31:16]));
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 9))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic mix_cmd_t make_cmd(func_t f, int id, int addr, int frames, int l, int r);
    mix_cmd_t c;
    c.func        = f;
    c.clip_id     = CLIP_ID_W'(id);
    c.address     = ADDR_W'(addr);
    c.clip_frames = POS_W'(frames);
    c.left_in     = SAMPLE_BITS'(l);
    c.right_in    = SAMPLE_BITS'(r);
    return c;
  endfunction

  // one mixing pass: voices in index order, then the scaled music frame
  task automatic mix_tick();
    int                       acc_l;
    int                       acc_r;
    int                       g;
    logic [CLIP_ID_W-1:0]     c;
    logic [FRAME_W-1:0]       w;
    logic signed [SAMPLE_BITS-1:0] sl;
    logic signed [SAMPLE_BITS-1:0] sr;
    mix_frame_t               f;
    acc_l = 0;
    acc_r = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (!voice_on[i]) continue;
      c = voice_clip_id[i];
      if (voice_pos[i] >= clip_len[c]) begin
        voice_on[i] = 1'b0;
        continue;
      end
      w = mem_frame[ADDR_W'(clip_first[c] + voice_pos[i])];
      sl = w[15:0];
      sr = w[31:16];
      acc_l += sl;
      acc_r += sr;
      voice_pos[i] = POS_W'(voice_pos[i] + 1);
    end
    if (music_on && music_len != 0) begin
      if (music_pos >= music_len)
        music_pos = (music_loop < music_len) ? POS_W'(music_loop) : '0;
      w = mem_frame[ADDR_W'(music_first + music_pos)];
      sl = w[15:0];
      sr = w[31:16];
      g = music_scale;
      // arithmetic shift gives the floor of the division by 256
      acc_l += (sl * g) >>> 8;
      acc_r += (sr * g) >>> 8;
      music_pos = POS_W'(music_pos + 1);
    end
    f.left = clamp16(acc_l);
    f.right = clamp16(acc_r);
    frames_due.push_back(f);
  endtask

  task automatic apply_cmd(input mix_cmd_t c);
    int  slot;
    bit  found;
    slot = 0;
    found = 1'b0;
    case (c.func)
      FUNC_PLAY: begin
        if (c.clip_id < NUM_CLIPS && clip_len[c.clip_id] != 0) begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (!found && !voice_on[i]) begin
              slot = i;
              found = 1'b1;
            end
          end
          voice_on[slot] = 1'b1;
          voice_clip_id[slot] = c.clip_id;
          voice_pos[slot] = '0;
        end
      end
      FUNC_WRITE: begin
        mem_frame[c.address] = {c.right_in, c.left_in};
        mem_written[c.address] = 1'b1;
      end
      FUNC_DESC: begin
        if (c.clip_id < NUM_CLIPS) begin
          clip_first[c.clip_id] = c.address;
          clip_len[c.clip_id] = c.clip_frames;
        end
      end
      default: mix_tick();
    endcase
  endtask

  // frame addresses the next tick will fetch
  function automatic void plan_tick_reads();
    logic [CLIP_ID_W-1:0] c;
    logic [POS_W-1:0]     p;
    fetch_addr.delete();
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (voice_on[i]) begin
        c = voice_clip_id[i];
        if (voice_pos[i] < clip_len[c])
          fetch_addr.push_back(ADDR_W'(clip_first[c] + voice_pos[i]));
      end
    end
    if (music_on && music_len != 0) begin
      p = music_pos;
      if (p >= music_len) p = (music_loop < music_len) ? POS_W'(music_loop) : '0;
      fetch_addr.push_back(ADDR_W'(music_first + p));
    end
  endfunction

  task automatic send_cmd(input mix_cmd_t c);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[OFS_CLIP_ID +: CLIP_ID_W] = c.clip_id;
    d[OFS_ADDR +: ADDR_W]       = c.address;
    d[OFS_FRAMES +: POS_W]      = c.clip_frames;
    d[OFS_LEFT +: SAMPLE_BITS]  = c.left_in;
    d[OFS_RIGHT +: SAMPLE_BITS] = c.right_in;
    s_tvalid <= 1'b1;
    valid_held = 1'b1;
    s_tdata <= d;
    s_tuser <= c.func;
    do @(posedge clk); while (!s_tready);
    apply_cmd(c);
    items_sent++;
    if (gaps_on) begin
      if (burst_left <= 1) begin
        s_tvalid <= 1'b0;
        valid_held = 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // fill every frame the tick would fetch that holds no data yet, then tick
  task automatic send_tick();
    mix_cmd_t c;
    plan_tick_reads();
    foreach (fetch_addr[k]) begin
      if (!mem_written[fetch_addr[k]]) begin
        c = make_cmd(FUNC_WRITE, $urandom_range(0, 7), fetch_addr[k],
                     $urandom_range(0, 65536), rand_sample(), rand_sample());
        send_cmd(c);
      end
    end
    c = make_cmd(FUNC_TICK, $urandom_range(0, 7), $urandom_range(0, 65535),
                 $urandom_range(0, 65536), rand_sample(), rand_sample());
    send_cmd(c);
  endtask

  task automatic drain();
    if (valid_held) begin
      s_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    burst_left = $urandom_range(1, 16);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [4:0] sel, input int en, input int base,
                            input int len, input int loop, input int gain);
    int       vals[5];
    reg_idx_t order[5];
    vals = '{en, base, len, loop, gain};
    // enable last, since writing it restarts the music
    order = '{REG_MUSIC_BASE, REG_MUSIC_LENGTH, REG_MUSIC_LOOP_START,
              REG_MUSIC_GAIN, REG_MUSIC_ENABLE};
    drain();
    foreach (order[k]) begin
      if (sel[order[k]]) begin
        cfg_we <= 1'b1;
        cfg_index <= order[k];
        cfg_data <= CFG_DATA_W'(vals[order[k]]);
        @(posedge clk);
        case (order[k])
          REG_MUSIC_ENABLE: begin
            music_on = vals[order[k]][0];
            music_pos = '0;
          end
          REG_MUSIC_BASE: music_first = ADDR_W'(vals[order[k]]);
          REG_MUSIC_LENGTH: music_len = POS_W'(vals[order[k]]);
          REG_MUSIC_LOOP_START: music_loop = ADDR_W'(vals[order[k]]);
          default: music_scale = GAIN_W'(vals[order[k]]);
        endcase
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_quiet_tick();
    ready_mode = READY_FULL;
    gaps_on = 1'b0;
    send_tick();
  endtask

  // address wrap at the top of memory, empty clip, descriptor changed mid-clip
  task automatic test_clip_voices();
    send_cmd(make_cmd(FUNC_WRITE, 0, 65535, 0, 32767, -32768));
    send_cmd(make_cmd(FUNC_WRITE, 0, 0, 0, -32768, 32767));
    send_cmd(make_cmd(FUNC_DESC, 7, 65535, 3, 0, 0));
    send_cmd(make_cmd(FUNC_PLAY, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(FUNC_PLAY, 7, 0, 0, 0, 0));
    send_tick();
    send_tick();
    send_cmd(make_cmd(FUNC_DESC, 7, 1000, 65536, 0, 0));
    send_tick();
    send_cmd(make_cmd(FUNC_DESC, 7, 1000, 2, 0, 0));
    send_tick();
    send_tick();
  endtask

  // twelve voices of full-scale samples, then a play that takes voice 0 back
  task automatic test_voice_steal();
    ready_mode = READY_CHOPPY;
    gaps_on = 1'b1;
    send_cmd(make_cmd(FUNC_WRITE, 0, 300, 0, 32767, -32768));
    send_cmd(make_cmd(FUNC_DESC, 5, 300, 4, 0, 0));
    repeat (NUM_VOICES) send_cmd(make_cmd(FUNC_PLAY, 5, 0, 0, 0, 0));
    send_tick();
    send_cmd(make_cmd(FUNC_PLAY, 5, 0, 0, 0, 0));
    repeat (5) send_tick();
  endtask

  task automatic test_music_loop();
    ready_mode = READY_FULL;
    gaps_on = 1'b0;
    write_regs(ALL_REGS, 1, 65533, 5, 3, 256);
    repeat (7) send_tick();
    write_regs(5'(1 << REG_MUSIC_GAIN), 0, 0, 0, 0, 0);
    send_tick();
    write_regs(5'(1 << REG_MUSIC_GAIN), 0, 0, 0, 0, 384);
    send_tick();
    // zero length: position holds
    write_regs(5'(1 << REG_MUSIC_LENGTH), 0, 0, 0, 0, 0);
    send_tick();
    send_tick();
    // length now below position with loop start past the end
    write_regs(5'(1 << REG_MUSIC_LENGTH), 0, 0, 2, 0, 0);
    send_tick();
    send_tick();
    write_regs(ALL_REGS, 1, 65535, 65536, 65535, 128);
    send_tick();
    send_tick();
    write_regs(5'(1 << REG_MUSIC_ENABLE), 0, 0, 0, 0, 0);
    send_tick();
  endtask

  task automatic test_random_mix();
    mix_cmd_t c;
    int       r;
    int       len;
    int       loop;
    int       gain;
    int       frames;
    int       phase_end;
    bit       held;
    for (int phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 4))
        0: len = 0;
        1: len = 65536;
        2: len = $urandom_range(1, 65536);
        default: len = $urandom_range(1, 48);
      endcase
      loop = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 47);
      case ($urandom_range(0, 3))
        0: gain = 0;
        1: gain = 256;
        default: gain = $urandom_range(0, 256);
      endcase
      write_regs(ALL_REGS, ($urandom_range(0, 3) != 0), $urandom_range(0, 65535),
                 len, loop, gain);
      case (phase)
        0: begin ready_mode = READY_FULL; gaps_on = 1'b0; end
        1: begin ready_mode = READY_CHOPPY; gaps_on = 1'b1; end
        2: begin ready_mode = READY_LONG_STALL; gaps_on = 1'b1; end
        default: begin ready_mode = READY_CHOPPY; gaps_on = 1'b0; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      held = 1'b0;
      while (items_sent < phase_end) begin
        // hold the sender until every frame has come back
        if (!held && items_sent >= phase_end - PHASE_ITEMS / 2) begin
          drain();
          held = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 40) begin
          send_tick();
        end else if (r < 60) begin
          send_cmd(make_cmd(FUNC_PLAY, $urandom_range(0, 7), $urandom_range(0, 65535),
                            $urandom_range(0, 65536), rand_sample(), rand_sample()));
        end else if (r < 75) begin
          send_cmd(make_cmd(FUNC_WRITE, $urandom_range(0, 7), $urandom_range(0, 65535),
                            $urandom_range(0, 65536), rand_sample(), rand_sample()));
        end else begin
          case ($urandom_range(0, 19))
            0, 1: frames = 0;
            2: frames = 65536;
            3: frames = $urandom_range(0, 65536);
            default: frames = $urandom_range(1, 24);
          endcase
          c = make_cmd(FUNC_DESC, $urandom_range(0, 7), $urandom_range(0, 65535),
                       frames, rand_sample(), rand_sample());
          send_cmd(c);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_quiet_tick();
    test_clip_voices();
    test_voice_steal();
    test_music_loop();
    test_random_mix();
    drain();
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
